### rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// Base64 decoder package
// Shared widths, codes, item and state types, and the alphabet lookup.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int CHAR_BITS   = 8;
   localparam int CAP_BITS    = 12;
   localparam int SEXTET_BITS = 7;

   localparam logic [CAP_BITS-1:0]    CAP_RESET     = 12'd4095;
   localparam logic [SEXTET_BITS-1:0] ALPHABET_SIZE = 7'd64;
   localparam logic [SEXTET_BITS-1:0] CODE_PLUS     = 7'h3e;
   localparam logic [SEXTET_BITS-1:0] CODE_SLASH    = 7'h3f;
   localparam logic [SEXTET_BITS-1:0] CODE_BAD      = 7'h40;

   // Decoder state that does not depend on the count width.
   typedef struct packed {
      logic [1:0]           phase;
      logic [CHAR_BITS-1:0] partial_byte;
      logic                 stopped;
   } state_type;

   // Payload of one result item.
   typedef struct packed {
      logic [CHAR_BITS-1:0] out_byte;
      logic                 byte_valid;
      logic [CAP_BITS-1:0]  byte_count;
      logic                 halted;
      logic                 end_of_string;
   } result_type;

   // Six-bit value of a character, or CODE_BAD outside the alphabet
   // (the pad character included).
   function automatic logic [SEXTET_BITS-1:0] sextet_of(input logic [CHAR_BITS-1:0] c);
      logic [SEXTET_BITS-1:0] v;
      v = CODE_BAD;
      if (c >= 8'h41 && c <= 8'h5a) begin
         v = SEXTET_BITS'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         v = SEXTET_BITS'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = SEXTET_BITS'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2b) begin
         v = CODE_PLUS;
      end else if (c == 8'h2f) begin
         v = CODE_SLASH;
      end
      return v;
   endfunction

endpackage

### rtl/b64d_if.sv
// ----------------------------------------------------------------------------
// Base64 decoder channels
// Valid/ready channel interfaces for characters, results and the capacity.
// ----------------------------------------------------------------------------
interface b64d_req_if;
   logic                            valid;
   logic                            ready;
   logic [b64d_pkg::CHAR_BITS-1:0]  char_in;
   logic                            last_char;

   modport source (output valid, char_in, last_char, input ready);
   modport sink   (input valid, char_in, last_char, output ready);
endinterface

interface b64d_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [b64d_pkg::CHAR_BITS-1:0]  out_byte;
   logic                            byte_valid;
   logic [b64d_pkg::CAP_BITS-1:0]   byte_count;
   logic                            halted;
   logic                            end_of_string;

   modport source (output valid, out_byte, byte_valid, byte_count, halted, end_of_string,
                   input ready);
   modport sink   (input valid, out_byte, byte_valid, byte_count, halted, end_of_string,
                   output ready);
endinterface

interface b64d_csr_if;
   logic                            valid;
   logic                            ready;
   logic [b64d_pkg::CAP_BITS-1:0]   max_output_bytes;

   modport source (output valid, max_output_bytes, input ready);
   modport sink   (input valid, max_output_bytes, output ready);
endinterface

### rtl/b64d_step.sv
// ----------------------------------------------------------------------------
// Base64 decoder step
// Next state, next count and the result item for one character.
// ----------------------------------------------------------------------------
module b64d_step #(
   parameter int COUNT_BITS = 12
) (
   input  logic [b64d_pkg::CAP_BITS-1:0]  cap,
   input  logic [b64d_pkg::CHAR_BITS-1:0] char_in,
   input  logic                           last_char,
   input  b64d_pkg::state_type            state_cur,
   input  logic [COUNT_BITS-1:0]          count_cur,
   output b64d_pkg::state_type            state_nxt,
   output logic [COUNT_BITS-1:0]          count_nxt,
   output b64d_pkg::result_type           result
);
   import b64d_pkg::*;

   localparam int CMP_BITS = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;

   localparam logic [1:0] PHASE_HIGH  = 2'd0;
   localparam logic [1:0] PHASE_SPLIT = 2'd1;
   localparam logic [1:0] PHASE_MID   = 2'd2;
   localparam logic [1:0] PHASE_LOW   = 2'd3;

   // The count is full at the capacity or at its own all-ones limit.
   function automatic logic is_full(input logic [COUNT_BITS-1:0] n,
                                    input logic [CAP_BITS-1:0]   c);
      return (CMP_BITS'(n) >= CMP_BITS'(c)) || (n == {COUNT_BITS{1'b1}});
   endfunction

   logic [SEXTET_BITS-1:0] sextet;
   logic [CHAR_BITS-1:0]   byte_val;
   logic [CHAR_BITS-1:0]   partial_nxt;
   logic                   emit;
   logic                   stop_pre;
   logic [COUNT_BITS-1:0]  count_inc;
   logic                   stop_run;
   logic [1:0]             phase_run;
   logic [CHAR_BITS-1:0]   partial_run;
   logic [COUNT_BITS-1:0]  count_run;
   logic [CMP_BITS-1:0]    count_wide;

   assign sextet    = sextet_of(char_in);
   assign stop_pre  = state_cur.stopped || is_full(count_cur, cap);
   assign count_inc = count_cur + COUNT_BITS'(1);

   always_comb begin
      byte_val    = '0;
      partial_nxt = '0;
      case (state_cur.phase)
         PHASE_HIGH: begin
            partial_nxt = {sextet[5:0], 2'b00};
         end
         PHASE_SPLIT: begin
            byte_val    = state_cur.partial_byte | {6'b0, sextet[5:4]};
            partial_nxt = {sextet[3:0], 4'b0000};
         end
         PHASE_MID: begin
            byte_val    = state_cur.partial_byte | {4'b0, sextet[5:2]};
            partial_nxt = {sextet[1:0], 6'b000000};
         end
         PHASE_LOW: begin
            byte_val    = state_cur.partial_byte | {2'b0, sextet[5:0]};
            partial_nxt = '0;
         end
         default: begin
            byte_val    = '0;
            partial_nxt = '0;
         end
      endcase
   end

   always_comb begin
      emit        = 1'b0;
      stop_run    = stop_pre;
      phase_run   = state_cur.phase;
      partial_run = state_cur.partial_byte;
      count_run   = count_cur;
      if (!stop_pre) begin
         if (sextet >= ALPHABET_SIZE) begin
            stop_run = 1'b1;
         end else begin
            phase_run   = state_cur.phase + 2'd1;
            partial_run = partial_nxt;
            if (state_cur.phase != PHASE_HIGH) begin
               emit      = 1'b1;
               count_run = count_inc;
               stop_run  = is_full(count_inc, cap);
            end
         end
      end
   end

   assign count_wide = CMP_BITS'(count_run);

   assign result.out_byte      = emit ? byte_val : '0;
   assign result.byte_valid    = emit;
   assign result.byte_count    = count_wide[CAP_BITS-1:0];
   assign result.halted        = stop_run;
   assign result.end_of_string = last_char;

   // The end of a string returns everything but the capacity to zero.
   assign state_nxt.phase        = last_char ? 2'd0 : phase_run;
   assign state_nxt.partial_byte = last_char ? '0 : partial_run;
   assign state_nxt.stopped      = last_char ? 1'b0 : stop_run;
   assign count_nxt              = last_char ? '0 : count_run;

endmodule

### rtl/base64_decoder_bounded.sv
// ----------------------------------------------------------------------------
// Bounded Base64 decoder
// Streams Base64 characters in and one result item out per character.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Contents                                        Ends at
//   -------  ---  ----------------------------------------------  ---------------
//   req      in   char_in, last_char                              valid && ready
//   rsp      out  out_byte, byte_valid, byte_count, halted, eos   valid && ready
//   csr      in   max_output_bytes (capacity, resets to 4095)     valid && ready
//
// An accepted character sits in the input register until the result register
// is free or being emptied, when the decode step updates the state and loads
// the result register, which offers the result until it is taken. One item
// per cycle is sustained while the result side does not stall; the decode
// step is the only logic between the two registers. Reset is synchronous; it
// empties both registers, clears the decoder state and returns the capacity to
// 4095. A stalled result register holds the input register, which in turn
// drops req.ready, so no item is lost or repeated under back pressure.
//
module base64_decoder_bounded #(
   parameter int COUNT_BITS = 12
) (
   input logic              clock,
   input logic              reset,
   b64d_req_if.sink         req,
   b64d_rsp_if.source       rsp,
   b64d_csr_if.sink         csr
);
   import b64d_pkg::*;

   // Input register.
   logic                  in_valid_ff, in_valid_in;
   logic [CHAR_BITS-1:0]  in_char_ff;
   logic                  in_last_ff;

   // Decoder state and the configured capacity.
   state_type             state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [CAP_BITS-1:0]   cap_ff;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            result_ff, result_in;

   logic                  req_take;
   logic                  step_go;

   // The step fires when a character waits and the result register is free
   // or being emptied in this same cycle.
   assign step_go   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || step_go;
   assign req_take  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign in_valid_in  = req_take ? 1'b1 : (step_go ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = step_go ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   b64d_step #(
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .cap        (cap_ff),
      .char_in    (in_char_ff),
      .last_char  (in_last_ff),
      .state_cur  (state_ff),
      .count_cur  (count_ff),
      .state_nxt  (state_in),
      .count_nxt  (count_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_go) begin
            state_ff <= state_in;
            count_ff <= count_in;
         end
         if (csr.valid) begin
            cap_ff <= csr.max_output_bytes;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req.char_in;
         in_last_ff <= req.last_char;
      end
      if (step_go) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_byte      = result_ff.out_byte;
   assign rsp.byte_valid    = result_ff.byte_valid;
   assign rsp.byte_count    = result_ff.byte_count;
   assign rsp.halted        = result_ff.halted;
   assign rsp.end_of_string = result_ff.end_of_string;

   // A result without a decoded byte carries a zero byte.
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !result_ff.byte_valid |-> result_ff.out_byte == '0)
      else $error("result without a byte carries a nonzero byte");

   // The last character of a string leaves the decoder fully cleared.
   a_string_clear: assert property (@(posedge clock) disable iff (reset)
      step_go && in_last_ff |=> count_ff == '0 && state_ff == '0)
      else $error("state not cleared after the end of a string");

   // Once halted, decoding stays halted until the string ends.
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      state_ff.stopped && !(step_go && in_last_ff) |=> state_ff.stopped)
      else $error("halt released before the end of the string");

   // The input register never advances into an occupied result register.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready && in_valid_ff |=> in_valid_ff && $stable(in_char_ff))
      else $error("character advanced while the result was stalled");

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Bounded Base64 decoder testbench
// Feeds character items through the decoder and checks every result item
// against the directed table or a predictor that runs in step with the
// accepted input. A short table of directed characters is followed by random
// strings under several capacity settings, with random idling on both
// channels and long result stalls that back the decoder up.
// ----------------------------------------------------------------------------
module tb_top;
   import b64d_pkg::*;

   localparam int COUNT_BITS     = 12;
   localparam int BACKLOG_CYCLES = 60;
   localparam int MAX_IDLE       = 17;

   localparam logic [CHAR_BITS-1:0]  PAD_CHAR  = "=";
   localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

   // One row of the directed table. When typed is set, res holds the result
   // that is expected for the character; otherwise the predictor decides.
   typedef struct packed {
      logic [CHAR_BITS-1:0] ch;
      logic                 is_last;
      logic                 typed;
      result_type           res;
   } stim_row_type;

   // Result fields in the rows below: out_byte, byte_valid, byte_count,
   // halted, end_of_string.
   localparam stim_row_type DIRECTED_ROWS [23] = '{
      // "TWFu" is the textbook encoding of "Man".
      {"T", 1'b0, 1'b1, 8'h00, 1'b0, 12'd0, 1'b0, 1'b0},
      {"W", 1'b0, 1'b1, 8'h4d, 1'b1, 12'd1, 1'b0, 1'b0},
      {"F", 1'b0, 1'b1, 8'h61, 1'b1, 12'd2, 1'b0, 1'b0},
      {"u", 1'b1, 1'b1, 8'h6e, 1'b1, 12'd3, 1'b0, 1'b1},
      // All ones from the top of the alphabet.
      {"/", 1'b0, 1'b0, 23'd0},
      {"/", 1'b0, 1'b0, 23'd0},
      {"/", 1'b0, 1'b0, 23'd0},
      {"/", 1'b1, 1'b0, 23'd0},
      // The ends of every range in the alphabet.
      {"Z", 1'b0, 1'b0, 23'd0},
      {"a", 1'b0, 1'b0, 23'd0},
      {"0", 1'b0, 1'b0, 23'd0},
      {"9", 1'b0, 1'b0, 23'd0},
      {"z", 1'b0, 1'b0, 23'd0},
      {"A", 1'b0, 1'b0, 23'd0},
      {"+", 1'b0, 1'b0, 23'd0},
      {"/", 1'b1, 1'b0, 23'd0},
      // A padded string halts on the first pad and stays halted.
      {"Q", 1'b0, 1'b1, 8'h00, 1'b0, 12'd0, 1'b0, 1'b0},
      {"Q", 1'b0, 1'b1, 8'h41, 1'b1, 12'd1, 1'b0, 1'b0},
      {"=", 1'b0, 1'b1, 8'h00, 1'b0, 12'd1, 1'b1, 1'b0},
      {"=", 1'b1, 1'b1, 8'h00, 1'b0, 12'd1, 1'b1, 1'b1},
      // A character outside the alphabet halts at once, and a valid
      // character after it is ignored.
      {8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 12'd0, 1'b1, 1'b0},
      {"A",   1'b0, 1'b1, 8'h00, 1'b0, 12'd0, 1'b1, 1'b0},
      {8'hff, 1'b1, 1'b1, 8'h00, 1'b0, 12'd0, 1'b1, 1'b1}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   b64d_req_if req_if ();
   b64d_rsp_if rsp_if ();
   b64d_csr_if csr_if ();

   base64_decoder_bounded #(.COUNT_BITS(COUNT_BITS)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state, updated once for every accepted character.
   logic [1:0]            dec_phase   = '0;
   logic [CHAR_BITS-1:0]  dec_partial = '0;
   logic [COUNT_BITS-1:0] dec_count   = '0;
   logic                  dec_stopped = 1'b0;
   logic [CAP_BITS-1:0]   capacity    = CAP_RESET;

   // Results that the decoder still owes, oldest first.
   result_type pending_results [$];

   // Both sides idle at random unless told to stay quiet. A backlog request
   // makes the result side hold off for a long stretch.
   bit req_quiet   = 1'b0;
   bit rsp_quiet   = 1'b0;
   bit backlog_req = 1'b0;

   int mismatch_count  = 0;
   int chars_sent      = 0;
   int results_checked = 0;
   int bytes_decoded   = 0;
   int halted_strings  = 0;
   int cap_writes      = 0;

   // Six-bit value of a character, or CODE_BAD for the pad and for anything
   // outside the alphabet.
   function automatic logic [SEXTET_BITS-1:0] char_value(input logic [CHAR_BITS-1:0] c);
      logic [CHAR_BITS-1:0] offset;
      offset = 8'd0;
      if (c == "+") return CODE_PLUS;
      if (c == "/") return CODE_SLASH;
      if (c >= "A" && c <= "Z") offset = c - "A";
      else if (c >= "a" && c <= "z") offset = c - "a" + 8'd26;
      else if (c >= "0" && c <= "9") offset = c - "0" + 8'd52;
      else return CODE_BAD;
      return offset[SEXTET_BITS-1:0];
   endfunction

   // Character that encodes a six-bit value.
   function automatic logic [CHAR_BITS-1:0] alpha_char(input logic [5:0] v);
      if (v < 6'd26) return "A" + CHAR_BITS'(v);
      if (v < 6'd52) return "a" + CHAR_BITS'(v - 6'd26);
      if (v < 6'd62) return "0" + CHAR_BITS'(v - 6'd52);
      return (v == 6'd62) ? "+" : "/";
   endfunction

   // The count also saturates at the top of its own width.
   function automatic logic capacity_reached();
      return (dec_count >= COUNT_BITS'(capacity)) || (dec_count == COUNT_TOP);
   endfunction

   // Works out the result for one character and advances the state.
   function automatic result_type decode_char(input logic [CHAR_BITS-1:0] c,
                                              input logic is_last);
      result_type r;
      logic [SEXTET_BITS-1:0] v;
      r = '0;
      v = char_value(c);
      // A full buffer, including a capacity lowered under the count, halts
      // before the character is looked at.
      if (!dec_stopped && capacity_reached()) dec_stopped = 1'b1;
      if (!dec_stopped) begin
         if (v == CODE_BAD) begin
            dec_stopped = 1'b1;
         end else begin
            case (dec_phase)
               2'd0: begin
                  dec_partial = {v[5:0], 2'b00};
               end
               2'd1: begin
                  r.out_byte   = dec_partial | {6'd0, v[5:4]};
                  r.byte_valid = 1'b1;
                  dec_partial  = {v[3:0], 4'd0};
               end
               2'd2: begin
                  r.out_byte   = dec_partial | {4'd0, v[5:2]};
                  r.byte_valid = 1'b1;
                  dec_partial  = {v[1:0], 6'd0};
               end
               default: begin
                  r.out_byte   = dec_partial | {2'd0, v[5:0]};
                  r.byte_valid = 1'b1;
                  dec_partial  = '0;
               end
            endcase
            dec_phase = dec_phase + 2'd1;
            if (r.byte_valid) begin
               dec_count = dec_count + 1'b1;
               // The byte that fills the buffer still goes out.
               if (capacity_reached()) dec_stopped = 1'b1;
            end
         end
      end
      r.byte_count    = dec_count[CAP_BITS-1:0];
      r.halted        = dec_stopped;
      r.end_of_string = is_last;
      if (is_last) begin
         dec_phase   = '0;
         dec_partial = '0;
         dec_count   = '0;
         dec_stopped = 1'b0;
      end
      return r;
   endfunction

   // Offers one character and waits for the decoder to take it. The valid
   // line is left high on return, so a following item with no gap keeps it
   // up without a second assignment in the same step.
   task automatic send_char(input logic [CHAR_BITS-1:0] c, input logic is_last,
                            input logic typed, input result_type typed_res);
      int gap;
      result_type predicted;
      gap = req_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.char_in   <= c;
      req_if.last_char <= is_last;
      do @(posedge clock); while (!req_if.ready);
      predicted = decode_char(c, is_last);
      pending_results.push_back(typed ? typed_res : predicted);
      chars_sent++;
   endtask

   // Sends a string of the given number of four-character groups. Most
   // strings are well formed, some with padding at the end; the rest mix in
   // pads and stray bytes, or are noise throughout.
   task automatic send_string(input int groups, input bit closed, input bit clean);
      logic [CHAR_BITS-1:0] text [$];
      int kind;
      int pick;
      int pad;
      int i;
      kind = clean ? 0 : $urandom_range(0, 9);
      for (i = 0; i < groups * 4; i++) begin
         pick = $urandom_range(0, 9);
         if (kind <= 6 || (kind <= 8 && pick < 8)) begin
            text.push_back(alpha_char(6'($urandom_range(0, 63))));
         end else if (kind <= 8 && pick == 8) begin
            text.push_back(PAD_CHAR);
         end else begin
            text.push_back(CHAR_BITS'($urandom_range(0, 255)));
         end
      end
      if (kind <= 6 && !clean) begin
         pad = $urandom_range(0, 2);
         for (i = 1; i <= pad; i++) text[text.size() - i] = PAD_CHAR;
      end
      for (i = 0; i < text.size(); i++) begin
         send_char(text[i], closed && (i == text.size() - 1), 1'b0, '0);
      end
   endtask

   // Drops the input valid and waits until every owed result has arrived.
   // Each character yields exactly one result, so the decoder is then idle.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_BITS-1:0] value);
      csr_if.valid            <= 1'b1;
      csr_if.max_output_bytes <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      capacity = value;
      cap_writes++;
   endtask

   task automatic report_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: ERROR %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Compares the result taken at this edge with the oldest expectation.
   task automatic check_result();
      result_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: ERROR unexpected result item, expected none, actual byte 0x%0h",
                  $time, rsp_if.out_byte);
         mismatch_count++;
      end else begin
         want = pending_results.pop_front();
         report_field("out_byte",      want.out_byte,      rsp_if.out_byte);
         report_field("byte_valid",    want.byte_valid,    rsp_if.byte_valid);
         report_field("byte_count",    want.byte_count,    rsp_if.byte_count);
         report_field("halted",        want.halted,        rsp_if.halted);
         report_field("end_of_string", want.end_of_string, rsp_if.end_of_string);
      end
      results_checked++;
      if (rsp_if.byte_valid) bytes_decoded++;
      if (rsp_if.end_of_string && rsp_if.halted) halted_strings++;
   endtask

   // Result side. Unless told to stay quiet, it stalls a random number of cycles
   // before each item, or for a long stretch when a backlog is asked for. The ready
   // line, like the input valid, changes at most once per step.
   initial begin : result_side
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (backlog_req) begin
            backlog_req = 1'b0;
            stall = BACKLOG_CYCLES;
         end else begin
            stall = rsp_quiet ? 0 : $urandom_range(0, MAX_IDLE);
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         check_result();
      end
   end

   // Stimulus and the end of the run.
   initial begin : stimulus
      int ph;
      int budget;
      logic [CAP_BITS-1:0] cap_value;
      req_if.valid            <= 1'b0;
      req_if.char_in          <= '0;
      req_if.last_char        <= 1'b0;
      csr_if.valid            <= 1'b0;
      csr_if.max_output_bytes <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // The directed table runs at the capacity left by reset.
      foreach (DIRECTED_ROWS[i]) begin
         send_char(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].is_last,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
      end
      drain();

      // A capacity of zero halts every string before its first byte.
      write_capacity('0);
      budget = chars_sent + 60;
      while (chars_sent < budget) send_string($urandom_range(1, 4), 1'b1, 1'b0);
      drain();

      // One long clean string with no idling runs into the capacity in the
      // middle of a group, and the characters after that are ignored.
      write_capacity(12'd119);
      req_quiet = 1'b1;
      rsp_quiet = 1'b1;
      send_string(45, 1'b1, 1'b1);
      drain();
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;

      // Random strings under small and random capacities. A string may be
      // left open across a capacity write, which can lower the capacity
      // below the count already reached.
      for (ph = 0; ph < 9; ph++) begin
         cap_value = (ph % 3 == 2) ? CAP_BITS'($urandom_range(0, 4095))
                                   : CAP_BITS'($urandom_range(1, 10));
         write_capacity(cap_value);
         req_quiet = (ph == 2) || (ph == 5) || (ph == 6);
         rsp_quiet = (ph == 5);
         // The sender keeps offering items while results are held back, so
         // the decoder fills up and stalls its input.
         if (ph == 2 || ph == 6) backlog_req = 1'b1;
         budget = chars_sent + 50;
         while (chars_sent < budget) begin
            send_string($urandom_range(1, 6), $urandom_range(0, 5) != 0, 1'b0);
         end
         drain();
      end
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;

      // Let the pipeline settle so that a stray late result is still seen.
      repeat (8) @(posedge clock);
      $display("tb: %0d characters over %0d capacity writes, %0d results checked",
               chars_sent, cap_writes, results_checked);
      $display("tb: %0d bytes decoded, %0d strings ended halted, %0d mismatches",
               bytes_decoded, halted_strings, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Guard against a hang.
   initial begin : watchdog
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
